FILE: sv/dsa_pkg.sv
// ---------------------------------------------------------------------------
// Daily step accumulator package
// Shared constants, controller/datapath handshake types and calendar helpers.
// ---------------------------------------------------------------------------
package dsa_pkg;

  // Sizes of the history and the counters
  localparam int HISTORY_DAYS = 7;
  localparam int SHOWN_DAYS   = 7;
  localparam int COUNT_BITS   = 24;
  localparam int OUT_W        = 24;
  localparam int RAW_W        = 32;
  localparam int TIME_W       = 64;
  localparam int YEAR_W       = 12;
  localparam int YDAY_W       = 9;
  localparam int KEY_W        = YEAR_W + YDAY_W;
  localparam int DN_W         = 24;
  localparam int CNT_W        = $clog2(HISTORY_DAYS + 1);

  localparam logic [TIME_W-1:0]     SAVE_INTERVAL_MS = TIME_W'(5 * 60 * 1000);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX        = '1;

  // Reciprocal of 100 scaled by 2^19, exact for 12-bit inputs
  localparam int DIV100_MUL   = 5243;
  localparam int DIV100_SHIFT = 19;
  localparam int DIV100_PW    = YEAR_W + 13;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COUNT,
    ST_DATE,
    ST_SHIFT,
    ST_SAVE,
    ST_OUT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic count_upd;
    logic date_upd;
    logic shift_step;
    logic save_chk;
    logic load_out;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic roll;
    logic shift_last;
    logic out_free;
  } stat_t;

  // floor(v / 100) by multiply and shift
  function automatic logic [YEAR_W-1:0] div100(input logic [YEAR_W-1:0] v);
    logic [DIV100_PW-1:0] prod;
    prod = DIV100_PW'(v) * DIV100_PW'(DIV100_MUL);
    return YEAR_W'(prod >> DIV100_SHIFT);
  endfunction

  // Day number of a {year, day-of-year} key, Gregorian leap rule
  function automatic logic signed [DN_W-1:0] day_number(input logic [KEY_W-1:0] key);
    logic [YEAR_W-1:0]      y;
    logic [YEAR_W-1:0]      q;
    logic [YEAR_W-1:0]      leaps;
    logic [YDAY_W-1:0]      d;
    logic signed [DN_W-1:0] p;
    y     = key[KEY_W-1:YDAY_W];
    d     = key[YDAY_W-1:0];
    p     = $signed(DN_W'(y)) - $signed(DN_W'(1));
    q     = (y == '0) ? '0 : y - YEAR_W'(1);
    leaps = (q >> 2) - div100(q) + div100(q >> 2);
    return p * $signed(DN_W'(365)) + $signed(DN_W'(leaps)) + $signed(DN_W'(d));
  endfunction

endpackage

FILE: sv/daily_step_accumulator_top.sv
// ---------------------------------------------------------------------------
// Daily step accumulator
// Folds raw pedometer counts into today's steps and a seven-day history,
// rolls days by the Gregorian calendar and paces save requests.
// ---------------------------------------------------------------------------
//  Channel | Handshake            | Payload
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_ready  | cmd, raw_steps, time_valid, cal_year,
//          |                      | year_day, uptime_ms
//  out     | out_valid / out_ready| today_steps, date_known, hist_day1..7,
//          |                      | save_request
//
//  Sequence: capture, count, date, save and output states; a roll inserts
//  one history shift state per day of gap (1 to HISTORY_DAYS) before save.
//  Reset: synchronous; clears counts, day key, history and save marks.
//  Stalls: the result sits in an output register; a new request is taken
//  while it waits, and the controller holds before loading the next result.
// ---------------------------------------------------------------------------
module daily_step_accumulator_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                cmd,
  input  logic [dsa_pkg::RAW_W-1:0]           raw_steps,
  input  logic                                time_valid,
  input  logic [dsa_pkg::YEAR_W-1:0]          cal_year,
  input  logic [dsa_pkg::YDAY_W-1:0]          year_day,
  input  logic [dsa_pkg::TIME_W-1:0]          uptime_ms,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [dsa_pkg::OUT_W-1:0]           today_steps,
  output logic                                date_known,
  output logic [dsa_pkg::OUT_W-1:0]           hist_day1,
  output logic [dsa_pkg::OUT_W-1:0]           hist_day2,
  output logic [dsa_pkg::OUT_W-1:0]           hist_day3,
  output logic [dsa_pkg::OUT_W-1:0]           hist_day4,
  output logic [dsa_pkg::OUT_W-1:0]           hist_day5,
  output logic [dsa_pkg::OUT_W-1:0]           hist_day6,
  output logic [dsa_pkg::OUT_W-1:0]           hist_day7,
  output logic                                save_request
);

  dsa_pkg::cmd_t           ctrl_cmd;
  dsa_pkg::stat_t          dp_stat;
  logic [dsa_pkg::OUT_W-1:0] hist_day [dsa_pkg::SHOWN_DAYS];

  // Sequencer
  dsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (dp_stat),
    .cmd_o    (ctrl_cmd)
  );

  // Datapath
  dsa_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd_i        (ctrl_cmd),
    .stat         (dp_stat),
    .cmd          (cmd),
    .raw_steps    (raw_steps),
    .time_valid   (time_valid),
    .cal_year     (cal_year),
    .year_day     (year_day),
    .uptime_ms    (uptime_ms),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .today_steps  (today_steps),
    .date_known   (date_known),
    .hist_day     (hist_day),
    .save_request (save_request)
  );

  // History ports
  assign hist_day1 = hist_day[0];
  assign hist_day2 = hist_day[1];
  assign hist_day3 = hist_day[2];
  assign hist_day4 = hist_day[3];
  assign hist_day5 = hist_day[4];
  assign hist_day6 = hist_day[5];
  assign hist_day7 = hist_day[6];

endmodule

FILE: sv/dsa_ctrl.sv
// ---------------------------------------------------------------------------
// Daily step accumulator controller
// Sequences one request through count, date, history shift, save and output.
// ---------------------------------------------------------------------------
module dsa_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  dsa_pkg::stat_t stat,
  output dsa_pkg::cmd_t  cmd_o
);

  dsa_pkg::state_t state;
  dsa_pkg::state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dsa_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd_o      = '0;
    in_ready   = 1'b0;
    unique case (state)
      dsa_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_o.capture = 1'b1;
          state_next    = dsa_pkg::ST_COUNT;
        end
      end
      dsa_pkg::ST_COUNT: begin
        cmd_o.count_upd = 1'b1;
        state_next      = dsa_pkg::ST_DATE;
      end
      dsa_pkg::ST_DATE: begin
        cmd_o.date_upd = 1'b1;
        state_next     = stat.roll ? dsa_pkg::ST_SHIFT : dsa_pkg::ST_SAVE;
      end
      dsa_pkg::ST_SHIFT: begin
        cmd_o.shift_step = 1'b1;
        if (stat.shift_last) begin
          state_next = dsa_pkg::ST_SAVE;
        end
      end
      dsa_pkg::ST_SAVE: begin
        cmd_o.save_chk = 1'b1;
        state_next     = dsa_pkg::ST_OUT;
      end
      dsa_pkg::ST_OUT: begin
        // wait until the previous result has been taken
        if (stat.out_free) begin
          cmd_o.load_out = 1'b1;
          state_next     = dsa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = dsa_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/dsa_datapath.sv
// ---------------------------------------------------------------------------
// Daily step accumulator datapath
// Step count, day key, history shift line, save pacing and output register.
// ---------------------------------------------------------------------------
module dsa_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  dsa_pkg::cmd_t                       cmd_i,
  output dsa_pkg::stat_t                      stat,
  input  logic                                cmd,
  input  logic [dsa_pkg::RAW_W-1:0]           raw_steps,
  input  logic                                time_valid,
  input  logic [dsa_pkg::YEAR_W-1:0]          cal_year,
  input  logic [dsa_pkg::YDAY_W-1:0]          year_day,
  input  logic [dsa_pkg::TIME_W-1:0]          uptime_ms,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [dsa_pkg::OUT_W-1:0]           today_steps,
  output logic                                date_known,
  output logic [dsa_pkg::OUT_W-1:0]           hist_day [dsa_pkg::SHOWN_DAYS],
  output logic                                save_request
);

  // Block state
  logic                               started;
  logic [dsa_pkg::RAW_W-1:0]          raw_base;
  logic [dsa_pkg::COUNT_BITS-1:0]     today_count;
  logic [dsa_pkg::KEY_W-1:0]          day_key;
  logic [dsa_pkg::COUNT_BITS-1:0]     history [dsa_pkg::HISTORY_DAYS];
  logic [dsa_pkg::TIME_W-1:0]         saved_time;
  logic [dsa_pkg::COUNT_BITS-1:0]     saved_count;
  logic [dsa_pkg::KEY_W-1:0]          saved_key;

  // Per-request working registers
  logic                               clear_req;
  logic [dsa_pkg::RAW_W-1:0]          raw_r;
  logic                               tv_r;
  logic [dsa_pkg::KEY_W-1:0]          key_r;
  logic [dsa_pkg::TIME_W-1:0]         now_r;
  logic signed [dsa_pkg::DN_W-1:0]    dn_new;
  logic signed [dsa_pkg::DN_W-1:0]    dn_old;
  logic [dsa_pkg::CNT_W-1:0]          shift_cnt;
  logic                               shift_first;
  logic                               saved_flag;

  // Combinational helpers
  logic [dsa_pkg::RAW_W-1:0]          base_eff;
  logic [dsa_pkg::RAW_W-1:0]          raw_diff;
  logic [dsa_pkg::RAW_W:0]            count_sum;
  logic [dsa_pkg::COUNT_BITS-1:0]     count_sat;
  logic signed [dsa_pkg::DN_W-1:0]    gap;
  logic [dsa_pkg::CNT_W-1:0]          shift_load;
  logic                               save_due;
  logic                               save_chg;
  logic [dsa_pkg::OUT_W-1:0]          hist_view [dsa_pkg::SHOWN_DAYS];

  // Raw counter growth, saturating add
  always_comb begin
    base_eff  = started ? raw_base : raw_r;
    raw_diff  = raw_r - base_eff;
    count_sum = (dsa_pkg::RAW_W + 1)'(today_count) + (dsa_pkg::RAW_W + 1)'(raw_diff);
    count_sat = (count_sum > (dsa_pkg::RAW_W + 1)'(dsa_pkg::COUNT_MAX))
              ? dsa_pkg::COUNT_MAX : count_sum[dsa_pkg::COUNT_BITS-1:0];
  end

  // Day gap clamped to 1..HISTORY_DAYS shifts
  always_comb begin
    gap = dn_new - dn_old;
    if (gap < $signed(dsa_pkg::DN_W'(1))) begin
      shift_load = dsa_pkg::CNT_W'(1);
    end else if (gap >= $signed(dsa_pkg::DN_W'(dsa_pkg::HISTORY_DAYS))) begin
      shift_load = dsa_pkg::CNT_W'(dsa_pkg::HISTORY_DAYS);
    end else begin
      shift_load = gap[dsa_pkg::CNT_W-1:0];
    end
  end

  // Save pacing
  assign save_chg = (today_count != saved_count) || (day_key != saved_key);
  assign save_due = (now_r - saved_time) >= dsa_pkg::SAVE_INTERVAL_MS;

  // Status to controller
  assign stat.roll       = tv_r && (day_key != '0) && (key_r > day_key);
  assign stat.shift_last = (shift_cnt == dsa_pkg::CNT_W'(1));
  assign stat.out_free   = !out_valid || out_ready;

  // History as shown: days past the history depth read zero
  for (genvar i = 0; i < dsa_pkg::SHOWN_DAYS; i++) begin : g_view
    if (i < dsa_pkg::HISTORY_DAYS) begin : g_have
      assign hist_view[i] = dsa_pkg::OUT_W'(history[i]);
    end else begin : g_none
      assign hist_view[i] = '0;
    end
  end

  // Request capture, day numbers and output load, no reset needed
  always_ff @(posedge clk) begin
    if (cmd_i.capture) begin
      clear_req <= cmd;
      raw_r     <= raw_steps;
      tv_r      <= time_valid;
      key_r     <= {cal_year, year_day};
      now_r     <= uptime_ms;
    end
    if (cmd_i.count_upd) begin
      dn_new <= dsa_pkg::day_number(key_r);
      dn_old <= dsa_pkg::day_number(day_key);
    end
    if (cmd_i.load_out) begin
      today_steps  <= dsa_pkg::OUT_W'(today_count);
      date_known   <= (day_key != '0);
      hist_day     <= hist_view;
      save_request <= saved_flag;
    end
  end

  // Block state and sequencing registers
  always_ff @(posedge clk) begin
    if (rst) begin
      started     <= 1'b0;
      raw_base    <= '0;
      today_count <= '0;
      day_key     <= '0;
      for (int i = 0; i < dsa_pkg::HISTORY_DAYS; i++) begin
        history[i] <= '0;
      end
      saved_time  <= '0;
      saved_count <= '0;
      saved_key   <= '0;
      shift_cnt   <= '0;
      shift_first <= 1'b0;
      saved_flag  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        saved_flag <= 1'b0;
      end

      // first request sets the base; then fold in raw growth
      if (cmd_i.count_upd) begin
        if (!started) begin
          saved_time  <= now_r;
          saved_count <= today_count;
          saved_key   <= day_key;
          started     <= 1'b1;
        end
        if (raw_r > base_eff) begin
          today_count <= count_sat;
        end
        raw_base <= raw_r;
      end

      // adopt the date, or take a backwards clock, or arm a roll
      if (cmd_i.date_upd && tv_r) begin
        if (day_key == '0) begin
          day_key <= key_r;
        end else if (key_r < day_key) begin
          day_key <= key_r;
        end
        if (stat.roll) begin
          shift_cnt   <= shift_load;
          shift_first <= 1'b1;
        end
      end

      // one history shift per cycle; the last one closes the day
      if (cmd_i.shift_step) begin
        for (int i = dsa_pkg::HISTORY_DAYS - 1; i > 0; i--) begin
          history[i] <= history[i-1];
        end
        history[0]  <= shift_first ? today_count : '0;
        shift_first <= 1'b0;
        shift_cnt   <= shift_cnt - dsa_pkg::CNT_W'(1);
        if (stat.shift_last) begin
          today_count <= '0;
          day_key     <= key_r;
          saved_time  <= now_r;
          saved_count <= '0;
          saved_key   <= key_r;
          saved_flag  <= 1'b1;
        end
      end

      // periodic save and clear-today command
      if (cmd_i.save_chk) begin
        if (clear_req) begin
          today_count <= '0;
          saved_time  <= now_r;
          saved_count <= '0;
          saved_key   <= day_key;
          saved_flag  <= 1'b1;
        end else if (save_chg && save_due) begin
          saved_time  <= now_r;
          saved_count <= today_count;
          saved_key   <= day_key;
          saved_flag  <= 1'b1;
        end
      end

      // output register
      if (cmd_i.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Checks
  a_shift_cnt_live: assert property (@(posedge clk) disable iff (rst)
    cmd_i.shift_step |-> (shift_cnt != '0))
    else $error("history shift with empty shift count");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd_i.load_out |-> (!out_valid || out_ready))
    else $error("pending result overwritten");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd_i.load_out |=> out_valid)
    else $error("loaded result not presented");

  a_started_sticks: assert property (@(posedge clk) disable iff (rst)
    started |=> started)
    else $error("started flag dropped");

  a_roll_saves: assert property (@(posedge clk) disable iff (rst)
    (cmd_i.shift_step && stat.shift_last) |=> (saved_flag && (today_count == '0)))
    else $error("day roll did not clear and save");

endmodule
